// ===== rtl/core/swmo_pkg.sv =====
// Shared types and codes for the stack with middle-entry operations.
package swmo_pkg;

   localparam int unsigned DATA_W = 32;
   localparam int unsigned OCC_W  = 7;

   typedef enum logic [1:0] {
      OP_PUSH = 2'd0,
      OP_POP  = 2'd1,
      OP_MID  = 2'd2,
      OP_DEL  = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   typedef struct packed {
      opcode_type               opcode;
      logic signed [DATA_W-1:0] push_value;
   } req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] value;
      status_type               status;
      logic [OCC_W-1:0]         occupancy;
   } rsp_type;

   // Broadcast from the sequencer to every cell in the chain.
   typedef struct packed {
      logic              go;
      opcode_type        opcode;
      logic [DATA_W-1:0] data;
   } cell_cmd_type;

endpackage

// ===== rtl/core/stack_with_middle_ops.sv =====
// Bounded stack with push, pop, read-middle and delete-middle on a chain of cells.
// The request lands in the issue register, then the cell chain executes and the response
// register loads; a stalled response side holds the request in the issue register.
// Throughput: one transaction per cycle while the response side is not stalled.
// Reset: synchronous, clears the entry count and the valid flags; cell data is not reset.
module stack_with_middle_ops #(
   parameter int unsigned DEPTH = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  swmo_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output swmo_pkg::rsp_type rsp_data
);

   localparam int unsigned CNT_W = $clog2(DEPTH + 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   logic                        busy_ff;
   logic                        busy_in;
   swmo_pkg::req_type           op_ff;
   swmo_pkg::req_type           op_in;
   logic [CNT_W-1:0]            count_ff;
   logic [CNT_W-1:0]            count_in;
   logic                        rsp_valid_ff;
   logic                        rsp_valid_in;
   swmo_pkg::rsp_type           rsp_ff;
   swmo_pkg::rsp_type           rsp_in;

   logic                        accept;
   logic                        exec;
   logic                        out_free;
   logic [CNT_W-1:0]            mid;
   logic                        empty;
   logic                        full;
   logic [swmo_pkg::DATA_W-1:0] read_value;
   swmo_pkg::cell_cmd_type      cmd;

   logic [swmo_pkg::DATA_W-1:0] entry_vals [DEPTH];
   logic [swmo_pkg::DATA_W-1:0] rd_vals    [DEPTH];

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign exec      = busy_ff && out_free;
   assign req_stall = busy_ff && !out_free;
   assign accept    = req_valid && !req_stall;

   // middle = ceil(n/2)-1; meaningless when empty, which is gated below
   assign mid   = CNT_W'(count_ff - CNT_W'(1)) >> 1;
   assign empty = (count_ff == '0);
   assign full  = (count_ff == FULL_CNT);

   assign cmd.go     = exec;
   assign cmd.opcode = op_ff.opcode;
   assign cmd.data   = op_ff.push_value;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [swmo_pkg::DATA_W-1:0] upper;
      if (i == DEPTH - 1) begin : g_top
         assign upper = '0;
      end else begin : g_mid
         assign upper = entry_vals[i+1];
      end
      swmo_cell #(
         .INDEX (i),
         .CNT_W (CNT_W)
      ) u_cell (
         .clock       (clock),
         .cmd         (cmd),
         .count       (count_ff),
         .mid         (mid),
         .upper_value (upper),
         .entry_value (entry_vals[i]),
         .rd_value    (rd_vals[i])
      );
   end

   // at most one cell selects, so an OR merge picks the read entry
   always_comb begin
      read_value = '0;
      for (int i = 0; i < DEPTH; i++) begin
         read_value = read_value | rd_vals[i];
      end
   end

   always_comb begin
      count_in        = count_ff;
      rsp_in.value    = '0;
      rsp_in.status   = swmo_pkg::ST_OK;
      if (op_ff.opcode == swmo_pkg::OP_PUSH) begin
         if (full) begin
            rsp_in.status = swmo_pkg::ST_FULL;
         end else begin
            count_in = count_ff + CNT_W'(1);
         end
      end else if (empty) begin
         rsp_in.status = swmo_pkg::ST_EMPTY;
      end else begin
         rsp_in.value = read_value;
         if (op_ff.opcode == swmo_pkg::OP_POP || op_ff.opcode == swmo_pkg::OP_DEL) begin
            count_in = count_ff - CNT_W'(1);
         end
      end
      rsp_in.occupancy = swmo_pkg::OCC_W'(count_in);
   end

   always_comb begin
      busy_in = busy_ff;
      if (accept) begin
         busy_in = 1'b1;
      end else if (exec) begin
         busy_in = 1'b0;
      end
      op_in = accept ? req_data : op_ff;
      rsp_valid_in = rsp_valid_ff;
      if (exec) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
         if (exec) begin
            count_ff <= count_in;
         end
      end
      op_ff <= op_in;
      if (exec) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_CNT)
      else $error("entry count above depth");

   a_push_grows: assert property (@(posedge clock) disable iff (reset)
      exec && op_ff.opcode == swmo_pkg::OP_PUSH && !full
      |=> count_ff == $past(count_ff) + CNT_W'(1))
      else $error("push did not grow the stack");

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.status != swmo_pkg::ST_OK |-> rsp_ff.value == '0)
      else $error("failed transaction returned a nonzero value");
`endif

endmodule

// ===== rtl/core/swmo_cell.sv =====
// One stack cell: holds an entry, loads on push, takes its upper neighbor on delete.
module swmo_cell #(
   parameter int unsigned INDEX = 0,
   parameter int unsigned CNT_W = 7
) (
   input  logic                        clock,
   input  swmo_pkg::cell_cmd_type      cmd,
   input  logic [CNT_W-1:0]            count,
   input  logic [CNT_W-1:0]            mid,
   input  logic [swmo_pkg::DATA_W-1:0] upper_value,
   output logic [swmo_pkg::DATA_W-1:0] entry_value,
   output logic [swmo_pkg::DATA_W-1:0] rd_value
);

   localparam logic [CNT_W-1:0] IDX  = CNT_W'(INDEX);
   localparam logic [CNT_W-1:0] IDX1 = CNT_W'(INDEX + 1);

   logic [swmo_pkg::DATA_W-1:0] entry_ff;
   logic [swmo_pkg::DATA_W-1:0] entry_in;
   logic                        below_top;
   logic                        load;
   logic                        shift;
   logic                        sel;

   assign below_top = (IDX1 < count);
   assign load  = cmd.go && (cmd.opcode == swmo_pkg::OP_PUSH) && (count == IDX);
   assign shift = cmd.go && (cmd.opcode == swmo_pkg::OP_DEL) && (IDX >= mid) && below_top;

   always_comb begin
      unique case (cmd.opcode)
         swmo_pkg::OP_POP:  sel = (IDX1 == count);
         swmo_pkg::OP_MID,
         swmo_pkg::OP_DEL:  sel = (IDX == mid);
         default:           sel = 1'b0;
      endcase
   end

   always_comb begin
      entry_in = entry_ff;
      if (load) begin
         entry_in = cmd.data;
      end else if (shift) begin
         entry_in = upper_value;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry_value = entry_ff;
   assign rd_value    = sel ? entry_ff : '0;

endmodule
